@@ rtl/cca_pkg.sv @@
// Shared types and constants of the configurable cellular automaton.
`default_nettype none
package cca_pkg;

	localparam int GRID_MAX_DEF      = 64;
	localparam int WINDOW_RADIUS_DEF = 2;

	localparam int COLOR_W = 24;
	localparam int GSIZE_W = 7;
	localparam int MASK_W  = 25;
	localparam int FATE_W  = 52;
	localparam int CFG_W   = 52;
	localparam int CIDX_W  = 2;

	localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;

	localparam logic [GSIZE_W-1:0] GSIZE_RST = 7'd64;
	localparam logic [MASK_W-1:0]  MASK_RST  = 25'd469440;
	localparam logic [FATE_W-1:0]  FATE_RST  = 52'd144;
	localparam logic [COLOR_W-1:0] BIRTH_RST = 24'd0;

	// Register indexes of the configuration port.
	localparam logic [CIDX_W-1:0] CFG_GRID_SIZE   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_NEIGHBOR    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_FATE_TABLE  = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_BIRTH_COLOR = 2'd3;

	// Action codes of an input word.
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_GEN   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	// Fate codes; every other code means death.
	localparam logic [1:0] FATE_KEEP   = 2'd1;
	localparam logic [1:0] FATE_CREATE = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [5:0]         row;
		logic [5:0]         col;
		logic [COLOR_W-1:0] color;
	} cca_in_t;

	typedef struct packed {
		logic [COLOR_W-1:0] read_color;
		logic               cell_alive;
	} cca_out_t;

endpackage
`default_nettype wire

@@ rtl/cca_fate.sv @@
// Fate lookup: live neighbor count to the new color of one cell.
`default_nettype none
module cca_fate import cca_pkg::*; #(
	parameter int CW = 5
) (
	input  wire logic [CW-1:0]      cnt,
	input  wire logic [FATE_W-1:0]  fate_table,
	input  wire logic [COLOR_W-1:0] own_color,
	input  wire logic [COLOR_W-1:0] birth_color,
	output logic [COLOR_W-1:0]      new_color
);

	logic [1:0] fate;

	assign fate = fate_table[2*cnt +: 2];

	always_comb begin
		case (fate)
			FATE_KEEP:   new_color = own_color;
			FATE_CREATE: new_color = birth_color;
			default:     new_color = WHITE;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/configurable_cellular_automaton.sv @@
// Top level of the configurable cellular automaton: control, cell store and scratch store.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_word  (action, row, col, color)
//  out     | output    | out_valid / out_ready  | out_word (read_color, cell_alive)
//  cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// A write is stored as it is accepted, a read passes S_READ and a clear whitens every cell
// of the cell store in S_CLR; each then ends in S_DONE. A generation steps each of the n*n active
// cells through S_GEN and S_GLAST, the window area being 25 at radius two, and then S_COPY:
// each cell reads its window one entry a cycle from the single read port of the cell store,
// then the scratch store is copied back a cell a cycle.
// After reset a clearing pass in S_INIT whitens every entry of the cell store; no word
// is accepted until it ends. The block takes one word at a time; the result sits in an
// output register, so a stalled output only holds the block at the end of the next word.
`default_nettype none
module configurable_cellular_automaton import cca_pkg::*; #(
	parameter int GRID_MAX      = GRID_MAX_DEF,
	parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cca_in_t           in_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cca_out_t               out_word,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	localparam int DEPTH = GRID_MAX * GRID_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(GRID_MAX);
	localparam int NW    = $clog2(GRID_MAX + 1);
	localparam int WS    = 2 * WINDOW_RADIUS + 1;
	localparam int KN    = WS * WS;
	localparam int KW    = $clog2(KN);
	localparam int DW    = $clog2(WS);
	localparam int CW    = $clog2(KN + 1);
	localparam int CTR   = (KN - 1) / 2;
	localparam logic [RW:0] RX = (RW+1)'(WINDOW_RADIUS);

	typedef enum logic [8:0] {
		S_INIT   = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_READ   = 9'b000000100,
		S_GEN    = 9'b000001000,
		S_GLAST  = 9'b000010000,
		S_COPY   = 9'b000100000,
		S_CDRAIN = 9'b001000000,
		S_CLR    = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] r, input logic [AW-1:0] c);
		addr_of = AW'(r * GRID_MAX + c);
	endfunction

	state_t state_q;

	logic [GSIZE_W-1:0] gsize_q;
	logic [MASK_W-1:0]  mask_q;
	logic [FATE_W-1:0]  fate_q;
	logic [COLOR_W-1:0] birth_q;

	logic [COLOR_W-1:0] cell_mem [DEPTH];
	logic [COLOR_W-1:0] next_mem [DEPTH];
	logic [COLOR_W-1:0] cell_rd_q, next_rd_q;

	logic [RW-1:0] r_q, c_q;
	logic [KW-1:0] k_q;
	logic [DW-1:0] dr_q, dc_q;
	logic [CW-1:0] cnt_q;
	logic [COLOR_W-1:0] own_q;
	logic [AW-1:0] clr_q;
	logic          inside_q;
	cca_out_t      res_q, out_q;
	logic          out_valid_q;

	logic take_s1, ctr_s1, cp_s1;
	logic [AW-1:0] wa_s1;

	// Active grid size, clamped to one through GRID_MAX.
	logic [NW-1:0] n_act;
	logic [RW-1:0] n_m1;
	always_comb begin
		if (gsize_q == '0) n_act = NW'(1);
		else if (int'(gsize_q) > GRID_MAX) n_act = NW'(GRID_MAX);
		else n_act = NW'(gsize_q);
	end
	assign n_m1 = RW'(n_act - NW'(1));

	logic          accept, in_inside;
	logic [AW-1:0] in_addr, cur_addr;
	assign accept    = in_valid && in_ready;
	assign in_inside = (NW'(in_word.row) < n_act || int'(in_word.row) < int'(n_act))
		&& (int'(in_word.row) < int'(n_act)) && (int'(in_word.col) < int'(n_act));
	assign in_addr   = addr_of(AW'(in_word.row), AW'(in_word.col));
	assign cur_addr  = addr_of(AW'(r_q), AW'(c_q));

	// Neighbor position: row and column shifted by the window offset, tested against the grid.
	logic [RW:0]   nr_ext, nc_ext;
	logic          nb_ok;
	logic [AW-1:0] nb_addr;
	assign nr_ext  = {1'b0, r_q} + (RW+1)'(dr_q);
	assign nc_ext  = {1'b0, c_q} + (RW+1)'(dc_q);
	assign nb_ok   = nr_ext >= RX && (nr_ext - RX) < (RW+1)'(n_act)
		&& nc_ext >= RX && (nc_ext - RX) < (RW+1)'(n_act);
	assign nb_addr = addr_of(AW'(RW'(nr_ext - RX)), AW'(RW'(nc_ext - RX)));

	// Count update from the word returned by the cell store.
	logic          rd_live;
	logic [CW-1:0] cnt_fin;
	logic [COLOR_W-1:0] own_fin, gen_color;
	assign rd_live = cell_rd_q != WHITE;
	assign cnt_fin = cnt_q + CW'(take_s1 && rd_live);
	assign own_fin = ctr_s1 ? cell_rd_q : own_q;

	cca_fate #(.CW(CW)) u_fate (
		.cnt         (cnt_fin),
		.fate_table  (fate_q),
		.own_color   (own_fin),
		.birth_color (birth_q),
		.new_color   (gen_color)
	);

	// Port steering of the cell store.
	logic          cell_we;
	logic [AW-1:0] cell_wa, cell_ra;
	logic [COLOR_W-1:0] cell_wd;
	always_comb begin
		cell_we = 1'b0;
		cell_wa = clr_q;
		cell_wd = WHITE;
		if (state_q == S_IDLE) begin
			cell_we = accept && in_word.action == ACT_WRITE && in_inside;
			cell_wa = in_addr;
			cell_wd = in_word.color;
		end else if (cp_s1) begin
			cell_we = 1'b1;
			cell_wa = wa_s1;
			cell_wd = next_rd_q;
		end else if (state_q == S_INIT || state_q == S_CLR) begin
			cell_we = 1'b1;
		end
	end
	assign cell_ra = (state_q == S_IDLE) ? in_addr : nb_addr;

	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		cell_rd_q <= cell_mem[cell_ra];
		if (state_q == S_GLAST) next_mem[cur_addr] <= gen_color;
		next_rd_q <= next_mem[cur_addr];
	end

	always_ff @(posedge clk) begin
		take_s1 <= state_q == S_GEN && mask_q[k_q] && nb_ok;
		ctr_s1  <= state_q == S_GEN && k_q == KW'(CTR);
		wa_s1   <= cur_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= GSIZE_RST;
			mask_q  <= MASK_RST;
			fate_q  <= FATE_RST;
			birth_q <= BIRTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_SIZE:   gsize_q <= cfg_data[GSIZE_W-1:0];
				CFG_NEIGHBOR:    mask_q  <= cfg_data[MASK_W-1:0];
				CFG_FATE_TABLE:  fate_q  <= cfg_data[FATE_W-1:0];
				CFG_BIRTH_COLOR: birth_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			dr_q        <= '0;
			dc_q        <= '0;
			cnt_q       <= '0;
			cp_s1       <= 1'b0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cp_s1 <= state_q == S_COPY;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (ctr_s1) own_q <= cell_rd_q;
			if (state_q != S_GLAST) cnt_q <= cnt_fin;
			case (state_q)
				S_INIT, S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= (state_q == S_INIT) ? S_IDLE : S_DONE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_q    <= '0;
						inside_q <= in_inside;
						r_q      <= '0;
						c_q      <= '0;
						k_q      <= '0;
						dr_q     <= '0;
						dc_q     <= '0;
						cnt_q    <= '0;
						case (in_word.action)
							ACT_READ:  state_q <= S_READ;
							ACT_GEN:   state_q <= S_GEN;
							ACT_CLEAR: state_q <= S_CLR;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_READ: begin
					if (inside_q) begin
						res_q.read_color <= cell_rd_q;
						res_q.cell_alive <= rd_live;
					end
					state_q <= S_DONE;
				end
				S_GEN: begin
					k_q <= k_q + KW'(1);
					if (dc_q == DW'(WS - 1)) begin
						dc_q <= '0;
						dr_q <= dr_q + DW'(1);
					end else begin
						dc_q <= dc_q + DW'(1);
					end
					if (k_q == KW'(KN - 1)) begin
						k_q     <= '0;
						dr_q    <= '0;
						dc_q    <= '0;
						state_q <= S_GLAST;
					end
				end
				S_GLAST: begin
					// The new color goes to the scratch store this cycle; move to the next cell.
					cnt_q   <= '0;
					state_q <= S_GEN;
					if (c_q == n_m1) begin
						c_q <= '0;
						if (r_q == n_m1) begin
							r_q     <= '0;
							state_q <= S_COPY;
						end else begin
							r_q <= r_q + RW'(1);
						end
					end else begin
						c_q <= c_q + RW'(1);
					end
				end
				S_COPY: begin
					if (c_q == n_m1) begin
						c_q <= '0;
						if (r_q == n_m1) begin
							r_q     <= '0;
							state_q <= S_CDRAIN;
						end else begin
							r_q <= r_q + RW'(1);
						end
					end else begin
						c_q <= c_q + RW'(1);
					end
				end
				S_CDRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
`default_nettype wire
